@@ design/ocmp_pkg.sv @@
`default_nettype none
package ocmp_pkg;
  localparam int CordicSteps = 16;
  localparam int DW = 64;
  localparam int AW = 34;
  localparam logic signed [AW-1:0] AngHalfPi = 34'sd1073741824;
  localparam logic signed [AW-1:0] AngPi = 34'sd2147483648;
  localparam logic signed [14:0] LatLimit = 15'sd16373;

  typedef enum logic {
    REG_CENTER_LONGITUDE = 1'b0,
    REG_CENTER_LATITUDE  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] z;
  } cordic_t;

  function automatic logic signed [AW-1:0] atan_lut(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
      15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
      21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
      24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
      27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
      30: v = 32'h00000001; default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction
endpackage
`default_nettype wire

@@ design/ocmp_if.sv @@
`default_nettype none
interface ocmp_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  modport source(output valid, pos_x, pos_y, pos_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface ocmp_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] map_x;
  logic signed [15:0] map_y;
  logic at_origin;
  modport source(output valid, map_x, map_y, at_origin, input ready);
  modport sink(input valid, map_x, map_y, at_origin, output ready);
endinterface

interface ocmp_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/oblique_cartesian_to_map_projection_core.sv @@
`default_nettype none
// Throughput: one item per cycle while the output is not stalled; four chained CORDIC pipelines set the depth.
// Whole pipe advances when the output register is free or being taken.
// Reset (rst, synchronous) clears valid bits and the two centre registers.
module oblique_cartesian_to_map_projection_core
  import ocmp_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicSteps
) (
  input wire logic clk,
  input wire logic rst,
  ocmp_in_if.sink  in_ch,
  ocmp_out_if.source out_ch,
  ocmp_cfg_if.sink cfg
);
  localparam int N = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int Lat = 4 * N + 1;

  logic signed [15:0] center_longitude;
  logic signed [14:0] center_latitude;
  logic en;
  logic [Lat-1:0] vld;
  logic [Lat-2:0] org;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_longitude <= '0;
      center_latitude <= '0;
    end else if (cfg.valid) begin
      case (reg_index_t'(cfg.index))
        REG_CENTER_LONGITUDE: center_longitude <= cfg.data;
        REG_CENTER_LATITUDE: center_latitude <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  logic signed [14:0] lat_c;
  always_comb begin
    lat_c = center_latitude;
    if (center_latitude > LatLimit) lat_c = LatLimit;
    if (center_latitude < -LatLimit) lat_c = -LatLimit;
  end

  // Stage 1: rotate (x,y) by -lon, gain-match z.
  cordic_t a_in, zg_in, a_out, zg_out;
  always_comb begin
    a_in.x = {{(DW-48){in_ch.pos_x[31]}}, in_ch.pos_x, 16'h0};
    a_in.y = {{(DW-48){in_ch.pos_y[31]}}, in_ch.pos_y, 16'h0};
    a_in.z = -({{(AW-32){center_longitude[15]}}, center_longitude, 16'h0});
    zg_in.x = {{(DW-48){in_ch.pos_z[31]}}, in_ch.pos_z, 16'h0};
    zg_in.y = '0;
    zg_in.z = '0;
  end
  ocmp_cordic #(.Steps(N), .Mode(0)) u_r1 (.clk(clk), .en(en), .d(a_in), .q(a_out));
  ocmp_cordic #(.Steps(N), .Mode(0)) u_g1 (.clk(clk), .en(en), .d(zg_in), .q(zg_out));

  // Latitude delayed to match stage-1 depth.
  logic signed [14:0] lat_d [0:N];
  assign lat_d[0] = lat_c;
  for (genvar i = 0; i < N; i++) begin : g_lat
    always_ff @(posedge clk) if (en) lat_d[i+1] <= lat_d[i];
  end

  // Stage 2: rotate (c,zk) by -lat, gain-match e.
  cordic_t b_in, eg_in, b_out, eg_out;
  always_comb begin
    b_in.x = a_out.x;
    b_in.y = zg_out.x;
    b_in.z = -({{(AW-31){lat_d[N][14]}}, lat_d[N], 16'h0});
    eg_in.x = a_out.y;
    eg_in.y = '0;
    eg_in.z = '0;
  end
  ocmp_cordic #(.Steps(N), .Mode(0)) u_r2 (.clk(clk), .en(en), .d(b_in), .q(b_out));
  ocmp_cordic #(.Steps(N), .Mode(0)) u_g2 (.clk(clk), .en(en), .d(eg_in), .q(eg_out));

  // Stage 3: vector (c,ek) for longitude, gain-match n.
  cordic_t v_in, ng_in, v_out, ng_out;
  always_comb begin
    v_in.x = b_out.x;
    v_in.y = eg_out.x;
    v_in.z = '0;
    ng_in.x = b_out.y;
    ng_in.y = '0;
    ng_in.z = '0;
  end
  ocmp_cordic #(.Steps(N), .Mode(1)) u_v1 (.clk(clk), .en(en), .d(v_in), .q(v_out));
  ocmp_cordic #(.Steps(N), .Mode(0)) u_g3 (.clk(clk), .en(en), .d(ng_in), .q(ng_out));

  logic signed [AW-1:0] lon_d [0:N];
  assign lon_d[0] = v_out.z;
  for (genvar i = 0; i < N; i++) begin : g_lon
    always_ff @(posedge clk) if (en) lon_d[i+1] <= lon_d[i];
  end

  // Stage 4: vector (h,nk) for latitude.
  cordic_t w_in, w_out;
  always_comb begin
    w_in.x = v_out.x;
    w_in.y = ng_out.x;
    w_in.z = '0;
  end
  ocmp_cordic #(.Steps(N), .Mode(1)) u_v2 (.clk(clk), .en(en), .d(w_in), .q(w_out));

  logic nonzero;
  assign nonzero = (in_ch.pos_x != '0) || (in_ch.pos_y != '0) || (in_ch.pos_z != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_ch.valid};
    end
  end
  always_ff @(posedge clk) begin
    if (en) org <= {org[Lat-3:0], !nonzero};
  end

  function automatic logic signed [15:0] sat16(input logic signed [AW-1:0] v);
    if (v > 34'sd32767) return 16'sh7FFF;
    if (v < -34'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic signed [AW-1:0] lx, ly;
  assign lx = (lon_d[N] + 34'sd32768) >>> 16;
  assign ly = (w_out.z + 34'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.at_origin <= org[Lat-2];
      out_ch.map_x <= org[Lat-2] ? 16'sd0 : sat16(lx);
      out_ch.map_y <= org[Lat-2] ? 16'sd0 : sat16(ly);
    end
  end
  assign out_ch.valid = vld[Lat-1];

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.map_x))
    else $error("result changed under stall");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.at_origin |-> out_ch.map_x == 16'sd0 && out_ch.map_y == 16'sd0)
    else $error("origin result not zero");
  a_lat: assert property (@(posedge clk) lat_c <= LatLimit && lat_c >= -LatLimit)
    else $error("latitude clamp");
`endif
endmodule
`default_nettype wire

@@ design/ocmp_stage.sv @@
`default_nettype none
// One CORDIC micro-rotation on a registered stage; mode 1 = vectoring.
module ocmp_stage
  import ocmp_pkg::*;
#(
  parameter int Step = 0,
  parameter int Mode = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire cordic_t d,
  output cordic_t q
);
  cordic_t r;
  logic signed [DW-1:0] dx, dy;
  logic dir;

  always_comb begin
    dx = d.x >>> Step;
    dy = d.y >>> Step;
    dir = (Mode == 0) ? !d.z[AW-1] : !d.y[DW-1];
    if (dir == (Mode == 0)) begin
      r.x = d.x - dy;
      r.y = d.y + dx;
    end else begin
      r.x = d.x + dy;
      r.y = d.y - dx;
    end
    if (dir) r.z = (Mode == 0) ? d.z - atan_lut(Step) : d.z + atan_lut(Step);
    else r.z = (Mode == 0) ? d.z + atan_lut(Step) : d.z - atan_lut(Step);
  end

  always_ff @(posedge clk) begin
    if (en) q <= r;
  end
endmodule
`default_nettype wire

@@ design/ocmp_cordic.sv @@
`default_nettype none
// Pipelined CORDIC pass with pre-rotation into the right half-plane.
module ocmp_cordic
  import ocmp_pkg::*;
#(
  parameter int Steps = CordicSteps,
  parameter int Mode = 0
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire cordic_t d,
  output cordic_t q
);
  localparam int N = (Steps < 32) ? Steps : 32;
  cordic_t p [0:N];
  cordic_t pre;

  always_comb begin
    pre = d;
    if (Mode == 0) begin
      if (d.z > AngHalfPi) begin
        pre.x = -d.x; pre.y = -d.y; pre.z = d.z - AngPi;
      end else if (d.z < -AngHalfPi) begin
        pre.x = -d.x; pre.y = -d.y; pre.z = d.z + AngPi;
      end
    end else begin
      pre.z = '0;
      if (d.x[DW-1]) begin
        pre.x = -d.x; pre.y = -d.y;
        pre.z = d.y[DW-1] ? -AngPi : AngPi;
      end
    end
  end

  assign p[0] = pre;
  for (genvar i = 0; i < N; i++) begin : g_st
    ocmp_stage #(.Step(i), .Mode(Mode)) u_st (.clk(clk), .en(en), .d(p[i]), .q(p[i+1]));
  end
  assign q = p[N];
endmodule
`default_nettype wire

@@ tb/sv/tb_oblique_cartesian_to_map_projection_core.sv @@
`timescale 1ns / 100ps
module tb_oblique_cartesian_to_map_projection_core;
  import ocmp_pkg::*;

  typedef struct packed {
    logic signed [15:0] map_x;
    logic signed [15:0] map_y;
    logic at_origin;
  } map_point_t;

  localparam longint HalfPiAng = 64'sd1073741824;
  localparam longint PiAng = 64'sd2147483648;
  localparam longint PoleClamp = 16373;
  localparam int DrainCycles = 4 * CordicSteps + 12;

  localparam longint ArcTan[32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000
  };

  logic clk;
  logic rst;

  ocmp_in_if in_ch();
  ocmp_out_if out_ch();
  ocmp_cfg_if cfg();

  oblique_cartesian_to_map_projection_core DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg(cfg.sink)
  );

  logic [15:0] centre_lon;
  logic [14:0] centre_lat;
  map_point_t expected_points[$];
  int mismatches;
  int burst_left;
  int stall_mode;
  int stall_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void cordic_rotate(inout longint x, inout longint y, input longint z);
    longint dx;
    longint dy;
    if (z > HalfPiAng) begin
      x = -x; y = -y; z = z - PiAng;
    end else if (z < -HalfPiAng) begin
      x = -x; y = -y; z = z + PiAng;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ArcTan[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ArcTan[i];
      end
    end
  endfunction

  function automatic longint gain_equalise(input longint v);
    longint x;
    longint y;
    x = v;
    y = 0;
    cordic_rotate(x, y, 0);
    return x;
  endfunction

  function automatic longint cordic_angle(input longint x_in, input longint y_in,
                                          output longint mag);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = x_in;
    y = y_in;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PiAng : -PiAng;
      x = -x; y = -y;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + ArcTan[i];
      end else begin
        x = x - dx; y = y + dy; z = z - ArcTan[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic logic signed [15:0] clip_q15(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic map_point_t project_point(input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] pz);
    map_point_t r;
    longint a, e, zk, c, n, ek, nk, h, hd, lon, lat, lon_rel, lat_rel;
    if (px == 0 && py == 0 && pz == 0) begin
      r.map_x = '0; r.map_y = '0; r.at_origin = 1'b1;
      return r;
    end
    lon = longint'($signed(centre_lon));
    lat = longint'($signed(centre_lat));
    if (lat > PoleClamp) lat = PoleClamp;
    if (lat < -PoleClamp) lat = -PoleClamp;
    a = longint'(px) * 65536;
    e = longint'(py) * 65536;
    cordic_rotate(a, e, -lon * 65536);
    zk = gain_equalise(longint'(pz) * 65536);
    c = a;
    n = zk;
    cordic_rotate(c, n, -lat * 65536);
    ek = gain_equalise(e);
    lon_rel = cordic_angle(c, ek, h);
    nk = gain_equalise(n);
    lat_rel = cordic_angle(h, nk, hd);
    r.map_x = clip_q15((lon_rel + 32768) >>> 16);
    r.map_y = clip_q15((lat_rel + 16384) >>> 15);
    r.at_origin = 1'b0;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    map_point_t exp_pt;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: map_x=%0d map_y=%0d at_origin=%0b",
                   out_ch.map_x, out_ch.map_y, out_ch.at_origin);
      end else begin
        exp_pt = expected_points.pop_front();
        if (out_ch.map_x !== exp_pt.map_x || out_ch.map_y !== exp_pt.map_y ||
            out_ch.at_origin !== exp_pt.at_origin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp (%0d,%0d,%0b) got (%0d,%0d,%0b)",
                     exp_pt.map_x, exp_pt.map_y, exp_pt.at_origin,
                     out_ch.map_x, out_ch.map_y, out_ch.at_origin);
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_pos(input logic signed [31:0] px, input logic signed [31:0] py,
                          input logic signed [31:0] pz);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    do @(posedge clk); while (!in_ch.ready);
    expected_points.push_back(project_point(px, py, pz));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    drain_pipe();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_CENTER_LONGITUDE) centre_lon = value;
    else centre_lat = value[14:0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_centre(input logic [15:0] lon, input logic [15:0] lat);
    write_reg(REG_CENTER_LONGITUDE, lon);
    write_reg(REG_CENTER_LATITUDE, lat);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 2000)) - 1000);
      1: return 32'h0;
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_origin_and_extremes();
    set_centre(16'h0000, 16'h0000);
    send_pos(0, 0, 0);
    send_pos(32'h7FFFFFFF, 0, 0);
    send_pos(32'h80000000, 0, 0);
    send_pos(0, 32'h7FFFFFFF, 0);
    send_pos(0, 32'h80000000, 0);
    send_pos(0, 0, 32'h7FFFFFFF);
    send_pos(0, 0, 32'h80000000);
    send_pos(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_pos(32'h80000000, 32'h80000000, 32'h80000000);
    send_pos(1, 0, 0);
    send_pos(0, 0, -1);
  endtask

  task automatic test_antimeridian();
    // directly behind the centre: relative longitude of +pi saturates
    send_pos(-1, 0, 0);
    send_pos(32'h80000000, 0, 1);
    set_centre(16'h8000, 16'h0000);
    send_pos(1, 0, 0);
    send_pos(-1000, 5, -7);
  endtask

  task automatic test_pole_clamp();
    set_centre(16'h7FFF, 16'h3FFF);
    send_pos(0, 0, 1000);
    send_pos(1000, -1000, 3);
    set_centre(16'h0001, 16'h4000);
    send_pos(0, 0, -1000);
    send_pos(-5, 77, 0);
    set_centre(16'h1234, 16'h3FF5);
    send_pos(0, 0, 32'h7FFFFFFF);
    set_centre(16'hC000, 16'hC00B);
    send_pos(10, 20, -30);
  endtask

  task automatic test_random_points();
    for (int i = 0; i < 900; i++) begin
      if (i % 150 == 0)
        set_centre(16'($urandom), 16'($urandom));
      if (i == 420) drain_pipe();
      send_pos(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_CENTER_LONGITUDE;
    cfg.data = '0;
    centre_lon = '0;
    centre_lat = '0;
    mismatches = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_origin_and_extremes();
    test_antimeridian();
    test_pole_clamp();
    test_random_points();
    drain_pipe();
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
